FILE: rtl/mlpq_pkg.sv
// Package with the shared types and constants of the multilevel priority queue.
`default_nettype none

package mlpq_pkg;

  localparam int LEVELS_DEF          = 10;
  localparam int DEPTH_PER_LEVEL_DEF = 16;
  localparam int NUMBER_WIDTH_DEF    = 16;

  localparam int NUM_FIELD_W  = 16;
  localparam int PRIO_FIELD_W = 4;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 24;

  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_SERVE   = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/multilevel_priority_fifo_queue_core.sv
// Top level of the multilevel priority queue with one FIFO of request numbers per level.
`default_nettype none

// Each priority level owns a ring of DEPTH_PER_LEVEL slots in one shared entry
// memory, with its head, tail and fill count held in registers. An enqueue
// transfer appends its number to its level, or is dropped with a status when the
// level is full or out of range. A serve transfer removes the oldest entry of the
// highest non-empty level. An enqueue and a serve on an empty queue set the result
// register directly. A serve that finds an entry registers the memory read word,
// then loads the result register from it in S_READ. The output register lets the
// next transfer be accepted in the same cycle as a waiting result is taken. The
// entry memory needs no clearing after reset, so the block is ready out of reset.
module multilevel_priority_fifo_queue_core #(
  parameter int LEVELS          = mlpq_pkg::LEVELS_DEF,
  parameter int DEPTH_PER_LEVEL = mlpq_pkg::DEPTH_PER_LEVEL_DEF,
  parameter int NUMBER_WIDTH    = mlpq_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: request_number[15:0], priority_req[19:16], zero fill.
  input  wire logic [mlpq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: kind.
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0: served_number[15:0], served_priority[19:16], zero fill.
  output logic [mlpq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [1:0]                           m_axis_tuser
);

  import mlpq_pkg::*;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = (DEPTH_PER_LEVEL > 1) ? $clog2(DEPTH_PER_LEVEL) : 1;
  localparam int CNT_W  = $clog2(DEPTH_PER_LEVEL + 1);
  localparam int ENTRIES = LEVELS * DEPTH_PER_LEVEL;
  localparam int ADDR_W = $clog2(ENTRIES);

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH_PER_LEVEL - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH_PER_LEVEL);
  localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(DEPTH_PER_LEVEL);

  logic [NUMBER_WIDTH-1:0] entry_mem [ENTRIES];
  logic [NUMBER_WIDTH-1:0] mem_rdata;

  logic [PTR_W-1:0] head_ptr [LEVELS];
  logic [PTR_W-1:0] tail_ptr [LEVELS];
  logic [CNT_W-1:0] level_cnt [LEVELS];

  state_t state;
  logic   out_valid;
  logic [1:0]              out_status;
  logic [NUM_FIELD_W-1:0]  out_number;
  logic [PRIO_FIELD_W-1:0] out_prio;
  logic [PRIO_FIELD_W-1:0] rd_prio;

  logic [NUM_FIELD_W-1:0]  in_number;
  logic [PRIO_FIELD_W-1:0] in_prio;
  logic                    in_kind;
  logic                    in_accept;
  logic                    out_accept;
  logic [LVL_W-1:0]        enq_lvl;
  logic                    enq_range_ok;
  logic                    enq_ok;
  logic                    any_ne;
  logic [LVL_W-1:0]        top_lvl;
  logic                    serve_hit;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;

  assign in_number = s_axis_tdata[NUM_FIELD_W-1:0];
  assign in_prio   = s_axis_tdata[NUM_FIELD_W +: PRIO_FIELD_W];
  assign in_kind   = s_axis_tuser;

  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_accept    = m_axis_tvalid && m_axis_tready;

  assign enq_range_ok = (32'(in_prio) < LEVELS);
  assign enq_lvl      = LVL_W'(in_prio);
  assign enq_ok       = enq_range_ok && (level_cnt[enq_lvl] != CNT_FULL);

  always_comb begin
    any_ne  = 1'b0;
    top_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (level_cnt[l] != '0) begin
        any_ne  = 1'b1;
        top_lvl = LVL_W'(l);
      end
    end
  end

  assign serve_hit = in_accept && (in_kind == KIND_SERVE) && any_ne;

  assign waddr = ADDR_W'(enq_lvl) * DEPTH_A + ADDR_W'(tail_ptr[enq_lvl]);
  assign raddr = ADDR_W'(top_lvl) * DEPTH_A + ADDR_W'(head_ptr[top_lvl]);

  always_ff @(posedge clk) begin
    if (in_accept && (in_kind == KIND_ENQUEUE) && enq_ok) begin
      entry_mem[waddr] <= NUMBER_WIDTH'(in_number);
    end
  end

  always_ff @(posedge clk) begin
    if (serve_hit) begin
      mem_rdata <= entry_mem[raddr];
      rd_prio   <= PRIO_FIELD_W'(top_lvl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_ptr[l]  <= '0;
        tail_ptr[l]  <= '0;
        level_cnt[l] <= '0;
      end
    end else if (in_accept) begin
      if (in_kind == KIND_ENQUEUE) begin
        if (enq_ok) begin
          tail_ptr[enq_lvl]  <= (tail_ptr[enq_lvl] == PTR_LAST) ? '0
                                : tail_ptr[enq_lvl] + PTR_W'(1);
          level_cnt[enq_lvl] <= level_cnt[enq_lvl] + CNT_W'(1);
        end
      end else if (any_ne) begin
        head_ptr[top_lvl]  <= (head_ptr[top_lvl] == PTR_LAST) ? '0
                              : head_ptr[top_lvl] + PTR_W'(1);
        level_cnt[top_lvl] <= level_cnt[top_lvl] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (serve_hit) begin
              state     <= S_READ;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_accept) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      out_status <= ST_SERVED;
      out_number <= NUM_FIELD_W'(mem_rdata);
      out_prio   <= rd_prio;
    end else if (in_accept && !serve_hit) begin
      out_number <= '0;
      out_prio   <= '0;
      if (in_kind == KIND_SERVE) begin
        out_status <= ST_EMPTY;
      end else if (enq_ok) begin
        out_status <= ST_ENQUEUED;
      end else begin
        out_status <= ST_DROPPED;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {{(OUT_DATA_W - NUM_FIELD_W - PRIO_FIELD_W){1'b0}},
                          out_prio, out_number};

  a_read_no_out: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !m_axis_tvalid)
    else $error("Result shown while the entry read is pending.");

  a_serve_reads: assert property (@(posedge clk) disable iff (rst)
    serve_hit |=> state == S_READ)
    else $error("A serve that found an entry did not start a read.");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> m_axis_tvalid && m_axis_tuser == ST_SERVED)
    else $error("Completed read did not present a served result.");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("Transfer accepted while the result register is held.");

endmodule

`default_nettype wire

FILE: tb/sv/mlpq_checker.sv
// Checker that predicts and compares every transfer of the multilevel priority queue.
module mlpq_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // Fields from bit 0: request_number[15:0], priority_req[19:16], zero fill.
  input  logic [mlpq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: kind.
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: served_number[15:0], served_priority[19:16], zero fill.
  input  logic [mlpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  input  logic [1:0]                      m_axis_tuser,
  output int                              mismatch_count,
  output int                              pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import mlpq_pkg::*;

  localparam int LEVELS = LEVELS_DEF;
  localparam int DEPTH  = DEPTH_PER_LEVEL_DEF;

  typedef struct packed {
    status_t                 status;
    logic [NUM_FIELD_W-1:0]  number;
    logic [PRIO_FIELD_W-1:0] level;
  } queue_result_t;

  logic [NUM_FIELD_W-1:0] ring_store [LEVELS][DEPTH];
  int                     head_slot  [LEVELS];
  int                     tail_slot  [LEVELS];
  int                     fill_level [LEVELS];
  queue_result_t          expected_results [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mlpq_checker: %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic apply_queue_op(input logic kind, input logic [NUM_FIELD_W-1:0] number,
                                input logic [PRIO_FIELD_W-1:0] level,
                                output queue_result_t res);
    int top_level;
    res = '{status: ST_ENQUEUED, number: '0, level: '0};
    if (kind == KIND_ENQUEUE) begin
      if (level >= LEVELS || fill_level[level] >= DEPTH) begin
        res.status = ST_DROPPED;
      end else begin
        ring_store[level][tail_slot[level]] = number;
        tail_slot[level] = (tail_slot[level] + 1) % DEPTH;
        fill_level[level]++;
      end
    end else begin
      top_level = -1;
      for (int l = LEVELS - 1; l >= 0 && top_level < 0; l--) begin
        if (fill_level[l] != 0) top_level = l;
      end
      if (top_level < 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status = ST_SERVED;
        res.number = ring_store[top_level][head_slot[top_level]];
        res.level  = top_level[PRIO_FIELD_W-1:0];
        head_slot[top_level] = (head_slot[top_level] + 1) % DEPTH;
        fill_level[top_level]--;
      end
    end
  endtask

  always @(posedge clk) begin
    queue_result_t res;
    queue_result_t want;
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_slot[l]  = 0;
        tail_slot[l]  = 0;
        fill_level[l] = 0;
      end
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_queue_op(s_axis_tuser, s_axis_tdata[NUM_FIELD_W-1:0],
                       s_axis_tdata[NUM_FIELD_W +: PRIO_FIELD_W], res);
        expected_results.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", int'(m_axis_tdata), 0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch("status", int'(m_axis_tuser), int'(want.status));
          if (m_axis_tdata[NUM_FIELD_W-1:0] != want.number)
            report_mismatch("served_number", int'(m_axis_tdata[NUM_FIELD_W-1:0]),
                            int'(want.number));
          if (m_axis_tdata[NUM_FIELD_W +: PRIO_FIELD_W] != want.level)
            report_mismatch("served_priority",
                            int'(m_axis_tdata[NUM_FIELD_W +: PRIO_FIELD_W]),
                            int'(want.level));
        end
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the multilevel priority queue testbench: stimulus, clock, reset and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mlpq_pkg::*;

  localparam int LEVELS      = LEVELS_DEF;
  localparam int DEPTH       = DEPTH_PER_LEVEL_DEF;
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = KIND_ENQUEUE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  int mismatch_count;
  int pending_count;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  multilevel_priority_fifo_queue_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mlpq_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic [NUM_FIELD_W-1:0] number,
                           input logic [PRIO_FIELD_W-1:0] level);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_DATA_W - NUM_FIELD_W - PRIO_FIELD_W){1'b0}}, level, number};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic run_directed();
    send_item(KIND_SERVE, 16'h1234, 4'd9);
    send_item(KIND_ENQUEUE, 16'hFFFF, 4'd15);
    send_item(KIND_ENQUEUE, 16'h0001, 4'd10);
    send_item(KIND_ENQUEUE, 16'h0000, 4'd0);
    send_item(KIND_ENQUEUE, 16'hFFFF, 4'd9);
    send_item(KIND_ENQUEUE, 16'hAAAA, 4'd5);
    send_item(KIND_ENQUEUE, 16'h5555, 4'd5);
    send_item(KIND_ENQUEUE, 16'h8001, 4'd0);
    for (int i = 0; i < 6; i++) send_item(KIND_SERVE, 16'hFFFF, 4'd15);
    for (int i = 0; i < DEPTH + 1; i++) send_item(KIND_ENQUEUE, 16'(i * 16'h1111), 4'd7);
  endtask

  task automatic run_random(input int item_total);
    int   sent;
    int   run_len;
    int   mode;
    int   enq_pct;
    logic kind;
    logic [PRIO_FIELD_W-1:0] level_a;
    logic [PRIO_FIELD_W-1:0] level_b;
    logic [PRIO_FIELD_W-1:0] level;
    sent = 0;
    while (sent < item_total) begin
      run_len = $urandom_range(40, 10);
      mode    = $urandom_range(2);
      level_a = PRIO_FIELD_W'($urandom_range(LEVELS - 1));
      level_b = PRIO_FIELD_W'($urandom_range(LEVELS - 1));
      enq_pct = (mode == 0) ? 90 : (mode == 1) ? 15 : 50;
      for (int i = 0; i < run_len && sent < item_total; i++) begin
        kind = ($urandom_range(99) < enq_pct) ? KIND_ENQUEUE : KIND_SERVE;
        if ($urandom_range(99) < 8) level = PRIO_FIELD_W'($urandom_range(15));
        else if (mode == 0) level = $urandom_range(1) ? level_a : level_b;
        else level = PRIO_FIELD_W'($urandom_range(LEVELS - 1));
        send_item(kind, NUM_FIELD_W'($urandom), level);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 62; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 62; end
        default: begin send_gap_pct = 18; stall_pct = 18; end
      endcase
      run_random(100);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
